// File: design/gls_pkg.sv
`default_nettype none

package gls_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 256;
   localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
   localparam int IDX_W       = $clog2(CELL_COUNT);
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int COL_CW      = $clog2(MAX_COLUMNS + 1);
   localparam int ROW_CW      = $clog2(MAX_ROWS + 1);
   localparam int ERR_W       = ((COL_W > ROW_W) ? COL_W : ROW_W) + 4;

   localparam int PIX_W      = 14;
   localparam int CELL_IN_W  = 16;
   localparam int TILE_W     = 7;
   localparam int TILE_MAX   = 64;
   localparam int GRID_REG_W = 9;

   localparam int DIV_LANES = 4;
   localparam int DIV_CNT_W = $clog2(PIX_W);
   localparam int LANE_X0   = 0;
   localparam int LANE_Y0   = 1;
   localparam int LANE_X1   = 2;
   localparam int LANE_Y1   = 3;

   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;
   localparam int REG_IDX_W = 2;

   localparam logic [REG_IDX_W-1:0] REG_TILE_WIDTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_GRID_COLS   = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS   = 2'd3;

   localparam logic [TILE_W-1:0]     TILE_RESET = 7'd16;
   localparam logic [GRID_REG_W-1:0] GRID_RESET = 9'd256;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic [TILE_W-1:0] tw;
      logic [TILE_W-1:0] th;
      logic [COL_CW-1:0] cols;
      logic [ROW_CW-1:0] rows;
   } cfg_type;

   typedef struct packed {
      logic mem_wr;
      logic div_start;
      logic setup;
      logic walk;
      logic drain;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic oor;
      logic step_stop;
      logic blocked_hit;
   } sts_type;

endpackage

`default_nettype wire

// File: design/gls_req_if.sv
`default_nettype none

interface gls_req_if import gls_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 req_type;
   logic [CELL_IN_W-1:0] cell_index;
   logic                 cell_blocked;
   logic [PIX_W-1:0]     from_x;
   logic [PIX_W-1:0]     from_y;
   logic [PIX_W-1:0]     to_x;
   logic [PIX_W-1:0]     to_y;

   modport source (
      output valid, req_type, cell_index, cell_blocked, from_x, from_y, to_x, to_y,
      input  ready
   );

   modport sink (
      input  valid, req_type, cell_index, cell_blocked, from_x, from_y, to_x, to_y,
      output ready
   );
endinterface

`default_nettype wire

// File: design/gls_rsp_if.sv
`default_nettype none

interface gls_rsp_if import gls_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             visible;
   logic             first_step_valid;
   logic [PIX_W-1:0] first_step_x;
   logic [PIX_W-1:0] first_step_y;
   logic             out_of_range;

   modport source (
      output valid, visible, first_step_valid, first_step_x, first_step_y, out_of_range,
      input  ready
   );

   modport sink (
      input  valid, visible, first_step_valid, first_step_x, first_step_y, out_of_range,
      output ready
   );
endinterface

`default_nettype wire

// File: design/grid_line_of_sight_top.sv
`default_nettype none

// Tile-grid line-of-sight unit. A write word (req_type 0) stores one cell's blocked flag
// and is accepted whenever the unit is idle. A query word (req_type 1) turns both pixel
// endpoints into tiles, walks the Bresenham line between them and returns one result
// word: visible, the pixel corner of the first stepped tile and out_of_range. A query
// runs the four shift-subtract divisions side by side, then the range check and line
// setup, then checks one cell per cycle on the single read port of the cell memory
// (N cells, N at most the larger of the tile distances plus one), drains the last read
// and loads the result register; an out-of-range line skips the walk and a blocked cell
// skips the drain. Only one query is at work at a time; the next word is accepted while
// a finished result still waits in the output register. Cells never written read as
// undefined; the size registers read back as written and are clamped to legal ranges.
module grid_line_of_sight_top import gls_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   gls_req_if.sink           req_chan,
   gls_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;
   logic    req_ready;
   logic    rsp_valid;

   gls_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gls_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cfg              (cfg),
      .cell_index       (req_chan.cell_index),
      .cell_blocked     (req_chan.cell_blocked),
      .from_x           (req_chan.from_x),
      .from_y           (req_chan.from_y),
      .to_x             (req_chan.to_x),
      .to_y             (req_chan.to_y),
      .visible          (rsp_chan.visible),
      .first_step_valid (rsp_chan.first_step_valid),
      .first_step_x     (rsp_chan.first_step_x),
      .first_step_y     (rsp_chan.first_step_y),
      .out_of_range     (rsp_chan.out_of_range)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

`default_nettype wire

// File: design/gls_csr.sv
`default_nettype none

module gls_csr import gls_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [TILE_W-1:0]     tw_ff;
   logic [TILE_W-1:0]     th_ff;
   logic [GRID_REG_W-1:0] cols_ff;
   logic [GRID_REG_W-1:0] rows_ff;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_AW-1:2];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff   <= TILE_RESET;
         th_ff   <= TILE_RESET;
         cols_ff <= GRID_RESET;
         rows_ff <= GRID_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_TILE_WIDTH:  tw_ff   <= pwdata[TILE_W-1:0];
            REG_TILE_HEIGHT: th_ff   <= pwdata[TILE_W-1:0];
            REG_GRID_COLS:   cols_ff <= pwdata[GRID_REG_W-1:0];
            REG_GRID_ROWS:   rows_ff <= pwdata[GRID_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TILE_WIDTH:  prdata = CSR_DW'(tw_ff);
         REG_TILE_HEIGHT: prdata = CSR_DW'(th_ff);
         REG_GRID_COLS:   prdata = CSR_DW'(cols_ff);
         REG_GRID_ROWS:   prdata = CSR_DW'(rows_ff);
         default:         prdata = '0;
      endcase
   end

   // clamp to the usable ranges
   always_comb begin
      if (tw_ff == '0) begin
         cfg.tw = TILE_W'(1);
      end else if (tw_ff > TILE_W'(TILE_MAX)) begin
         cfg.tw = TILE_W'(TILE_MAX);
      end else begin
         cfg.tw = tw_ff;
      end
      if (th_ff == '0) begin
         cfg.th = TILE_W'(1);
      end else if (th_ff > TILE_W'(TILE_MAX)) begin
         cfg.th = TILE_W'(TILE_MAX);
      end else begin
         cfg.th = th_ff;
      end
      if (cols_ff == '0) begin
         cfg.cols = COL_CW'(1);
      end else if (32'(cols_ff) > MAX_COLUMNS) begin
         cfg.cols = COL_CW'(MAX_COLUMNS);
      end else begin
         cfg.cols = COL_CW'(cols_ff);
      end
      if (rows_ff == '0) begin
         cfg.rows = ROW_CW'(1);
      end else if (32'(rows_ff) > MAX_ROWS) begin
         cfg.rows = ROW_CW'(MAX_ROWS);
      end else begin
         cfg.rows = ROW_CW'(rows_ff);
      end
   end

endmodule

`default_nettype wire

// File: design/gls_div.sv
`default_nettype none

module gls_div import gls_pkg::*; (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [DIV_LANES-1:0][PIX_W-1:0]     num,
   input  logic [DIV_LANES-1:0][TILE_W-1:0]    den,
   output logic [DIV_LANES-1:0][PIX_W-1:0]     quo,
   output logic                                done
);

   logic [DIV_LANES-1:0][PIX_W-1:0]  q_ff;
   logic [DIV_LANES-1:0][PIX_W-1:0]  q_in;
   logic [DIV_LANES-1:0][TILE_W-2:0] rem_ff;
   logic [DIV_LANES-1:0][TILE_W-2:0] rem_in;
   logic [DIV_LANES-1:0][TILE_W-1:0] rem_sh;
   logic [DIV_CNT_W-1:0]             cnt_ff;
   logic                             busy_ff;
   logic                             done_ff;

   // one restoring step per cycle on every lane
   always_comb begin
      for (int i = 0; i < DIV_LANES; i++) begin
         rem_sh[i] = {rem_ff[i], q_ff[i][PIX_W-1]};
         if (rem_sh[i] >= den[i]) begin
            rem_in[i] = (TILE_W-1)'(rem_sh[i] - den[i]);
            q_in[i]   = {q_ff[i][PIX_W-2:0], 1'b1};
         end else begin
            rem_in[i] = rem_sh[i][TILE_W-2:0];
            q_in[i]   = {q_ff[i][PIX_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(PIX_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         rem_ff <= '0;
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign quo  = q_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

// File: design/gls_dp.sv
`default_nettype none

module gls_dp import gls_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  cfg_type              cfg,
   input  logic [CELL_IN_W-1:0] cell_index,
   input  logic                 cell_blocked,
   input  logic [PIX_W-1:0]     from_x,
   input  logic [PIX_W-1:0]     from_y,
   input  logic [PIX_W-1:0]     to_x,
   input  logic [PIX_W-1:0]     to_y,
   output logic                 visible,
   output logic                 first_step_valid,
   output logic [PIX_W-1:0]     first_step_x,
   output logic [PIX_W-1:0]     first_step_y,
   output logic                 out_of_range
);

   logic [DIV_LANES-1:0][PIX_W-1:0]  num;
   logic [DIV_LANES-1:0][TILE_W-1:0] den;
   logic [DIV_LANES-1:0][PIX_W-1:0]  quo;
   logic                             div_done;

   logic mem [CELL_COUNT];
   logic mem_q_ff;
   logic wr_ok;
   logic [IDX_W-1:0] wr_addr;

   // walker state
   logic [COL_W-1:0]        x_ff, x1_ff, xs_ff, fxt_ff, x_in;
   logic [ROW_W-1:0]        y_ff, y1_ff, ys_ff, fyt_ff, y_in;
   logic [COL_W-1:0]        dx_ff;
   logic [ROW_W-1:0]        ady_ff;
   logic                    sx_ff, sy_ff;
   logic signed [ERR_W-1:0] err_ff, err_in, err_a, e2, dx_s, dy_s;
   logic [IDX_W-1:0]        idx_ff, idx_in, xd, yd;
   logic                    set_ff, blk_ff, blk0_ff, oor_ff;
   logic                    chk_ff, rd_first_ff, at_start_ff;
   logic                    a_take, b_take, stop_a, stop_b, x_move, y_move;

   // setup values
   logic [COL_W-1:0] x0, x1, dx0;
   logic [ROW_W-1:0] y0, y1, ady0;
   logic             sx0, sy0, oor;
   logic [31:0]      row_base;
   logic [IDX_W-1:0] idx0;

   // result
   logic [COL_W-1:0] tx;
   logic [ROW_W-1:0] ty;
   logic [31:0]      px, py;
   logic             fs_ok;

   assign num[LANE_X0] = from_x;
   assign num[LANE_Y0] = from_y;
   assign num[LANE_X1] = to_x;
   assign num[LANE_Y1] = to_y;
   assign den[LANE_X0] = cfg.tw;
   assign den[LANE_Y0] = cfg.th;
   assign den[LANE_X1] = cfg.tw;
   assign den[LANE_Y1] = cfg.th;

   gls_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num),
      .den   (den),
      .quo   (quo),
      .done  (div_done)
   );

   // cell store
   assign wr_ok   = 32'(cell_index) < CELL_COUNT;
   assign wr_addr = IDX_W'(cell_index);

   always_ff @(posedge clock) begin
      if (cmd.mem_wr && wr_ok) begin
         mem[wr_addr] <= cell_blocked;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk) begin
         mem_q_ff <= mem[idx_ff];
      end
   end

   // tile coordinates and line setup
   always_comb begin
      oor = (quo[LANE_X0] >= PIX_W'(cfg.cols)) || (quo[LANE_X1] >= PIX_W'(cfg.cols)) ||
            (quo[LANE_Y0] >= PIX_W'(cfg.rows)) || (quo[LANE_Y1] >= PIX_W'(cfg.rows));
      x0   = quo[LANE_X0][COL_W-1:0];
      y0   = quo[LANE_Y0][ROW_W-1:0];
      x1   = quo[LANE_X1][COL_W-1:0];
      y1   = quo[LANE_Y1][ROW_W-1:0];
      sx0  = x0 < x1;
      sy0  = y0 < y1;
      dx0  = sx0 ? (x1 - x0) : (x0 - x1);
      ady0 = sy0 ? (y1 - y0) : (y0 - y1);
      row_base = 32'(y0) * 32'(cfg.cols);
      idx0     = row_base[IDX_W-1:0] + IDX_W'(x0);
   end

   // one line step
   always_comb begin
      dx_s   = $signed(ERR_W'(dx_ff));
      dy_s   = -$signed(ERR_W'(ady_ff));
      e2     = $signed({err_ff[ERR_W-2:0], 1'b0});
      a_take = e2 >= dy_s;
      b_take = e2 <= dx_s;
      stop_a = a_take && (x_ff == x1_ff);
      stop_b = !stop_a && b_take && (y_ff == y1_ff);
      x_move = a_take && !stop_a;
      y_move = b_take && !stop_a && !stop_b;
      err_a  = x_move ? (err_ff + dy_s) : err_ff;
      err_in = y_move ? (err_a + dx_s) : err_a;
      x_in   = x_move ? (sx_ff ? (x_ff + COL_W'(1)) : (x_ff - COL_W'(1))) : x_ff;
      y_in   = y_move ? (sy_ff ? (y_ff + ROW_W'(1)) : (y_ff - ROW_W'(1))) : y_ff;
      xd     = x_move ? (sx_ff ? IDX_W'(1) : '1) : '0;
      yd     = y_move ? (sy_ff ? IDX_W'(cfg.cols) : (IDX_W'(0) - IDX_W'(cfg.cols))) : '0;
      idx_in = idx_ff + xd + yd;
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         x_ff        <= x0;
         y_ff        <= y0;
         x1_ff       <= x1;
         y1_ff       <= y1;
         xs_ff       <= x0;
         ys_ff       <= y0;
         sx_ff       <= sx0;
         sy_ff       <= sy0;
         dx_ff       <= dx0;
         ady_ff      <= ady0;
         err_ff      <= $signed(ERR_W'(dx0)) - $signed(ERR_W'(ady0));
         idx_ff      <= idx0;
         oor_ff      <= oor;
         set_ff      <= 1'b0;
         blk_ff      <= 1'b0;
         blk0_ff     <= 1'b0;
         chk_ff      <= 1'b0;
         at_start_ff <= 1'b1;
      end else begin
         if (cmd.walk) begin
            chk_ff      <= 1'b1;
            rd_first_ff <= at_start_ff;
            at_start_ff <= 1'b0;
            if (!stop_a && !stop_b) begin
               x_ff   <= x_in;
               y_ff   <= y_in;
               err_ff <= err_in;
               idx_ff <= idx_in;
               if (!set_ff) begin
                  fxt_ff <= x_in;
                  fyt_ff <= y_in;
                  set_ff <= 1'b1;
               end
            end
         end else if (cmd.drain) begin
            chk_ff <= 1'b0;
         end
         if ((cmd.walk || cmd.drain) && chk_ff && mem_q_ff) begin
            blk_ff <= 1'b1;
            if (rd_first_ff) begin
               blk0_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.div_done    = div_done;
   assign sts.oor         = oor;
   assign sts.step_stop   = stop_a || stop_b;
   assign sts.blocked_hit = chk_ff && mem_q_ff;

   // result word
   always_comb begin
      tx    = set_ff ? fxt_ff : xs_ff;
      ty    = set_ff ? fyt_ff : ys_ff;
      px    = 32'(tx) * 32'(cfg.tw);
      py    = 32'(ty) * 32'(cfg.th);
      fs_ok = !oor_ff && !blk0_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         visible          <= !oor_ff && !blk_ff;
         first_step_valid <= fs_ok;
         first_step_x     <= fs_ok ? px[PIX_W-1:0] : '0;
         first_step_y     <= fs_ok ? py[PIX_W-1:0] : '0;
         out_of_range     <= oor_ff;
      end
   end

endmodule

`default_nettype wire

// File: design/gls_ctrl.sv
`default_nettype none

module gls_ctrl import gls_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_type,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_RANGE = 3'd2;
   localparam logic [2:0] S_WALK  = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == REQ_WRITE) begin
                  cmd.mem_wr = 1'b1;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            cmd.setup = 1'b1;
            state_in  = sts.oor ? S_DONE : S_WALK;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (sts.blocked_hit) begin
               state_in = S_DONE;
            end else if (sts.step_stop) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.drain = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid_ff)
      else $error("result word overwritten");

   a_query_divides: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_type == REQ_QUERY) |=> (state_ff == S_DIV))
      else $error("query did not start the divider");

   a_oor_skips_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RANGE && sts.oor) |=> (state_ff == S_DONE))
      else $error("walk started on an out of range line");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result word raised outside done");

endmodule

`default_nettype wire
